// ===== rtl/sawbc_pkg.sv =====
// shared types and codes for the set-associative write-back cache
// no dependencies
package sawbc_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_ACCESS
  } state_t;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

endpackage

// ===== rtl/sawbc_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module sawbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/set_assoc_lru_writeback_cache_unit.sv =====
// set-associative write-back byte cache with true lru over a backing memory
// depends on sawbc_pkg and sawbc_ram
//
// usage:
//   request channel: command, address, write_data with in_valid / in_ready.
//   result channel: read_data, hit, was_dirty with out_valid / out_ready.
//   a read request gives one result, a write request gives none.
// timing:
//   a request goes through accept (set metadata read), lookup (tag
//   compare, lru update, line read from data or backing memory) and access
//   (merge byte, fill, write-back of a dirty victim, result); the next request
//   is taken only back in idle; the line read follows the metadata ram read.
//   a read result is written to the output register in access, once it is free.
// reset:
//   rst clears control state and starts a clearing pass over all
//   2**(ADDRESS_BITS - log2(BYTES_PER_LINE)) backing memory lines (16384 with
//   the defaults), one line per cycle; no request is taken until it ends.
//   set metadata reads as its reset value until first written.
// stall:
//   a read that finds the result register still full waits in access; a new
//   request is taken while a finished result waits to be taken.
module set_assoc_lru_writeback_cache_unit #(
  parameter int NUM_SETS       = 16,
  parameter int NUM_WAYS       = 6,
  parameter int BYTES_PER_LINE = 4,
  parameter int ADDRESS_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    command,
  input  logic [ADDRESS_BITS-1:0] address,
  input  logic [7:0]              write_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              read_data,
  output logic                    hit,
  output logic                    was_dirty
);
  import sawbc_pkg::*;

  localparam int OFF_W      = $clog2(BYTES_PER_LINE);
  localparam int SET_W      = $clog2(NUM_SETS);
  localparam int TAG_W      = ADDRESS_BITS - OFF_W - SET_W;
  localparam int WAY_W      = $clog2(NUM_WAYS);
  localparam int ENT_W      = TAG_W + 2 + WAY_W;
  localparam int META_W     = NUM_WAYS * ENT_W;
  localparam int LINE_W     = 8 * BYTES_PER_LINE;
  localparam int LADDR_W    = ADDRESS_BITS - OFF_W;
  localparam int DATA_DEPTH = NUM_SETS * NUM_WAYS;
  localparam int DATA_AW    = $clog2(DATA_DEPTH);
  localparam int BACK_DEPTH = 2 ** LADDR_W;
  localparam int META_AW    = (NUM_SETS > 1) ? SET_W : 1;

  state_t state, state_next;

  // request registers
  logic                    cmd_q;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic [7:0]              wdata_q;
  logic [OFF_W-1:0]        off_q;
  logic [SET_W-1:0]        set_q;
  logic [TAG_W-1:0]        tag_q;

  // lookup results
  logic             hit_q;
  logic             dflag_q;
  logic             wb_q;
  logic [WAY_W-1:0] way_q;
  logic [TAG_W-1:0] vtag_q;

  logic [LADDR_W-1:0] clr_cnt;
  logic [NUM_SETS-1:0] row_init;

  // ram ports
  logic              meta_we, meta_re;
  logic [META_AW-1:0] meta_waddr, meta_raddr;
  logic [META_W-1:0] meta_wdata, meta_rdata;
  logic              data_we, data_re;
  logic [DATA_AW-1:0] data_waddr, data_raddr;
  logic [LINE_W-1:0] data_wdata, data_rdata;
  logic              back_we, back_re;
  logic [LADDR_W-1:0] back_waddr, back_raddr;
  logic [LINE_W-1:0] back_wdata, back_rdata;

  // unpacked metadata of the looked-up set
  logic [TAG_W-1:0] m_tag   [NUM_WAYS];
  logic             m_valid [NUM_WAYS];
  logic             m_dirty [NUM_WAYS];
  logic [WAY_W-1:0] m_rank  [NUM_WAYS];

  logic [NUM_WAYS-1:0] hit_vec, vic_vec;
  logic [WAY_W-1:0]    hit_way, vic_way, way_sel;
  logic                any_hit;
  logic [WAY_W-1:0]    sel_rank;

  logic [LINE_W-1:0] line_src, line_new;
  logic [7:0]        byte_rd;
  logic              out_free;
  logic              access_done;

  assign off_q = addr_q[OFF_W-1:0];
  assign set_q = addr_q[OFF_W +: SET_W];
  assign tag_q = addr_q[ADDRESS_BITS-1 -: TAG_W];

  sawbc_ram #(.WIDTH(META_W), .DEPTH(NUM_SETS)) u_meta (
    .clk, .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .re(meta_re), .raddr(meta_raddr), .rdata(meta_rdata)
  );

  sawbc_ram #(.WIDTH(LINE_W), .DEPTH(DATA_DEPTH)) u_data (
    .clk, .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
    .re(data_re), .raddr(data_raddr), .rdata(data_rdata)
  );

  sawbc_ram #(.WIDTH(LINE_W), .DEPTH(BACK_DEPTH)) u_back (
    .clk, .we(back_we), .waddr(back_waddr), .wdata(back_wdata),
    .re(back_re), .raddr(back_raddr), .rdata(back_rdata)
  );

  // metadata decode, a row never written reads as its reset value
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (row_init[set_q]) begin
        m_tag[w]   = meta_rdata[w*ENT_W + 2 + WAY_W +: TAG_W];
        m_valid[w] = meta_rdata[w*ENT_W + 1 + WAY_W];
        m_dirty[w] = meta_rdata[w*ENT_W + WAY_W];
        m_rank[w]  = meta_rdata[w*ENT_W +: WAY_W];
      end else begin
        m_tag[w]   = '0;
        m_valid[w] = 1'b0;
        m_dirty[w] = 1'b0;
        m_rank[w]  = WAY_W'(w);
      end
    end
  end

  always_comb begin
    hit_way = '0;
    vic_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      hit_vec[w] = m_valid[w] && (m_tag[w] == tag_q);
      vic_vec[w] = (m_rank[w] == WAY_W'(NUM_WAYS - 1));
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (vic_vec[w]) begin
        vic_way = WAY_W'(w);
      end
    end
    any_hit  = |hit_vec;
    way_sel  = any_hit ? hit_way : vic_way;
    sel_rank = m_rank[way_sel];
  end

  // updated metadata row: fill, dirty and lru touch
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WAY_W'(w) == way_sel) begin
        meta_wdata[w*ENT_W + 2 + WAY_W +: TAG_W] = tag_q;
        meta_wdata[w*ENT_W + 1 + WAY_W]          = 1'b1;
        meta_wdata[w*ENT_W + WAY_W]              = any_hit ? (m_dirty[w] | cmd_q) : cmd_q;
        meta_wdata[w*ENT_W +: WAY_W]             = '0;
      end else begin
        meta_wdata[w*ENT_W + 2 + WAY_W +: TAG_W] = m_tag[w];
        meta_wdata[w*ENT_W + 1 + WAY_W]          = m_valid[w];
        meta_wdata[w*ENT_W + WAY_W]              = m_dirty[w];
        meta_wdata[w*ENT_W +: WAY_W] = (m_rank[w] < sel_rank) ? m_rank[w] + 1'b1 : m_rank[w];
      end
    end
  end

  // line merge for the access step
  always_comb begin
    line_src = hit_q ? data_rdata : back_rdata;
    line_new = line_src;
    byte_rd  = '0;
    for (int b = 0; b < BYTES_PER_LINE; b++) begin
      if (OFF_W'(b) == off_q) begin
        byte_rd = line_src[b*8 +: 8];
        if (cmd_q == CMD_WRITE) begin
          line_new[b*8 +: 8] = wdata_q;
        end
      end
    end
  end

  assign out_free    = !out_valid || out_ready;
  assign access_done = (cmd_q == CMD_WRITE) || out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_next = ST_ACCESS;
      ST_ACCESS: begin
        if (access_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE);
    meta_re    = (state == ST_IDLE) && in_valid;
    meta_raddr = META_AW'(address[OFF_W +: SET_W]);
    meta_we    = (state == ST_LOOKUP);
    meta_waddr = META_AW'(set_q);
    data_re    = (state == ST_LOOKUP);
    data_raddr = DATA_AW'(DATA_AW'(set_q) * DATA_AW'(NUM_WAYS)) + DATA_AW'(way_sel);
    data_we    = (state == ST_ACCESS) && (!hit_q || cmd_q == CMD_WRITE);
    data_waddr = DATA_AW'(DATA_AW'(set_q) * DATA_AW'(NUM_WAYS)) + DATA_AW'(way_q);
    data_wdata = line_new;
    back_re    = (state == ST_LOOKUP);
    back_raddr = {tag_q, set_q};
    back_we    = 1'b0;
    back_waddr = {vtag_q, set_q};
    back_wdata = data_rdata;
    case (state)
      ST_CLEAR: begin
        back_we    = 1'b1;
        back_waddr = clr_cnt;
        back_wdata = '0;
      end
      ST_ACCESS: back_we = wb_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      row_init  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == ST_LOOKUP) begin
        row_init[set_q] <= 1'b1;
      end
      if (state == ST_ACCESS && cmd_q == CMD_READ && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q   <= command;
      addr_q  <= address;
      wdata_q <= write_data;
    end
    if (state == ST_LOOKUP) begin
      hit_q   <= any_hit;
      way_q   <= way_sel;
      dflag_q <= m_dirty[way_sel];
      wb_q    <= !any_hit && m_valid[way_sel] && m_dirty[way_sel];
      vtag_q  <= m_tag[way_sel];
    end
    if (state == ST_ACCESS && cmd_q == CMD_READ && out_free) begin
      read_data <= byte_rd;
      hit       <= hit_q;
      was_dirty <= dflag_q;
    end
  end

`ifndef SYNTHESIS
  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOKUP |-> $onehot0(hit_vec))
    else $error("more than one way hit");

  a_one_victim: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOKUP |-> $onehot(vic_vec))
    else $error("lru ranks do not name exactly one victim");

  a_wb_dirty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACCESS && back_we) |-> (dflag_q && !hit_q))
    else $error("write-back of a line that was not a dirty victim");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |=> !in_ready)
    else $error("request taken while a lookup is in flight");
`endif

endmodule

// ===== sim/set_assoc_lru_writeback_cache_unit_tb.sv =====
// testbench for the set-associative write-back lru byte cache
// depends on sawbc_pkg and set_assoc_lru_writeback_cache_unit; self-checking against
// an in-bench cache and backing memory model
`timescale 1ns / 100ps

module set_assoc_lru_writeback_cache_unit_tb;
  import sawbc_pkg::*;

  localparam int SETS = 16;
  localparam int WAYS = 6;
  localparam int LINE = 4;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic       hit;
    logic       dirty;
  } read_result_t;

  class cache_scoreboard;
    logic [9:0] tags [SETS][WAYS];
    logic [7:0] bytes [SETS][WAYS][LINE];
    bit dirty [SETS][WAYS];
    bit valid [SETS][WAYS];
    int rank [SETS][WAYS];
    logic [7:0] mem [65536];
    read_result_t pending_reads[$];
    int mismatches;

    function void clear();
      for (int s = 0; s < SETS; s++)
        for (int w = 0; w < WAYS; w++) begin
          tags[s][w] = '0;
          dirty[s][w] = 0;
          valid[s][w] = 0;
          rank[s][w] = w;
          for (int j = 0; j < LINE; j++) bytes[s][w][j] = '0;
        end
      for (int a = 0; a < 65536; a++) mem[a] = '0;
      pending_reads.delete();
      mismatches = 0;
    endfunction

    function void note_request(logic cmd, logic [15:0] addr, logic [7:0] wdata);
      int off, s, way, r;
      logic [9:0] tg;
      bit found;
      logic dflag;
      read_result_t res;
      off = addr[1:0];
      s = addr[5:2];
      tg = addr[15:6];
      found = 0;
      way = 0;
      for (int w = 0; w < WAYS; w++)
        if (!found && valid[s][w] && tags[s][w] == tg) begin
          found = 1;
          way = w;
        end
      if (!found) begin
        for (int w = 0; w < WAYS; w++)
          if (rank[s][w] == WAYS - 1) way = w;
        if (valid[s][way] && dirty[s][way])
          for (int j = 0; j < LINE; j++)
            mem[{tags[s][way], 4'(s), 2'(j)}] = bytes[s][way][j];
        for (int j = 0; j < LINE; j++)
          bytes[s][way][j] = mem[{tg, 4'(s), 2'(j)}];
      end
      dflag = dirty[s][way];
      if (!found) begin
        tags[s][way] = tg;
        valid[s][way] = 1;
        dirty[s][way] = 0;
      end
      r = rank[s][way];
      for (int w = 0; w < WAYS; w++)
        if (rank[s][w] < r) rank[s][w]++;
      rank[s][way] = 0;
      if (cmd == CMD_WRITE) begin
        bytes[s][way][off] = wdata;
        dirty[s][way] = 1;
      end else begin
        res.data = bytes[s][way][off];
        res.hit = found;
        res.dirty = dflag;
        pending_reads.push_back(res);
      end
    endfunction

    function void check_result(logic [7:0] data, logic h, logic d);
      read_result_t want;
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result data=%h hit=%b dirty=%b", data, h, d);
        return;
      end
      want = pending_reads.pop_front();
      if (want.data !== data || want.hit !== h || want.dirty !== d) begin
        mismatches++;
        if (mismatches <= 10)
          $display("read mismatch: expected data=%h hit=%b dirty=%b, got data=%h hit=%b dirty=%b",
                   want.data, want.hit, want.dirty, data, h, d);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic command = CMD_READ;
  logic [15:0] address = '0;
  logic [7:0] write_data = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [7:0] read_data;
  logic hit;
  logic was_dirty;
  int cycles = 0;
  int stall_mode = 0;
  bit stimulus_done = 0;
  cache_scoreboard cache_model = new();

  set_assoc_lru_writeback_cache_unit dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // sample outputs at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) cache_model.check_result(read_data, hit, was_dirty);
    if (cycles > LIMIT) begin
      $display("set_assoc_lru_writeback_cache_unit_tb: errors");
      $finish;
    end
  end

  // receiver back-pressure, mode changes now and then
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_request(logic cmd, logic [15:0] addr, logic [7:0] wdata);
    in_valid <= 1'b1;
    command <= cmd;
    address <= addr;
    write_data <= wdata;
    do @(posedge clk); while (!in_ready);
    cache_model.note_request(cmd, addr, wdata);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // addresses from a few tags per set so lines get reused and evicted
  function automatic logic [15:0] pick_address();
    logic [15:0] a;
    a = 16'($urandom);
    if ($urandom_range(0, 4) != 0)
      a[15:6] = 10'($urandom_range(0, 8)) | (a[15] ? 10'h3f0 : 10'h0);
    return a;
  endfunction

  initial begin
    int burst;
    cache_model.clear();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: extremes, reads of cold lines, fill of one set past its ways
    send_request(CMD_READ, 16'h0000, 8'h00);
    send_request(CMD_READ, 16'hffff, 8'hff);
    send_request(CMD_WRITE, 16'hffff, 8'hff);
    send_request(CMD_READ, 16'hffff, 8'h00);
    send_request(CMD_WRITE, 16'h0000, 8'h5a);
    send_request(CMD_READ, 16'h0000, 8'h00);
    for (int t = 1; t <= 7; t++) send_request(CMD_WRITE, {10'(t * 37), 4'h0, 2'(t)}, 8'(t * 29));
    send_request(CMD_READ, 16'h0000, 8'h00);
    send_request(CMD_READ, {10'd37, 4'h0, 2'd1}, 8'h00);
    send_request(CMD_READ, {10'h2aa, 4'ha, 2'd2}, 8'haa);
    send_request(CMD_WRITE, {10'h155, 4'h5, 2'd1}, 8'h55);
    send_request(CMD_READ, {10'h155, 4'h5, 2'd1}, 8'h00);
    for (int i = 0; i < 450; i += burst) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++)
        send_request(($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ, pick_address(),
                     8'($urandom));
      idle_gap();
    end
    in_valid <= 1'b0;
    stimulus_done = 1;
  end

  initial begin
    wait (stimulus_done);
    while (cache_model.pending_reads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (cache_model.mismatches == 0)
      $display("set_assoc_lru_writeback_cache_unit_tb: clean");
    else
      $display("set_assoc_lru_writeback_cache_unit_tb: errors");
    $finish;
  end

endmodule
